// ===== rtl/yuyv_pair_to_bgr888_assert.svh =====
// assertion macros shared by the yuyv pair to bgr888 rtl
`ifndef YUYV_PAIR_TO_BGR888_ASSERT_SVH
`define YUYV_PAIR_TO_BGR888_ASSERT_SVH

`ifndef SYNTHESIS

// checked property, quiet while reset is asserted
`define YPB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("yuyv to bgr check failed");

// checked property that also holds through reset
`define YPB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("yuyv to bgr check failed");

`else

`define YPB_ASSERT(label, clk, rst_n, prop)
`define YPB_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/ypbgr_pkg.sv =====
// types and constants of the yuyv pair to bgr888 converter
`default_nettype none

package ypbgr_pkg;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned COEF_W   = 18;
    localparam int unsigned PROD_W   = COEF_W + SAMPLE_W;
    // luma << 16 plus products, with a sign bit and headroom
    localparam int unsigned ACC_W    = PROD_W + 1;

    // q16 coefficients, rounded to nearest
    localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd92242;
    localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd46983;
    localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22643;
    localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd116589;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t luma_first;
        sample_t chroma_blue;
        sample_t luma_second;
        sample_t chroma_red;
    } yuyv_beat_t;

    typedef struct packed {
        sample_t blue_first;
        sample_t green_first;
        sample_t red_first;
        sample_t blue_second;
        sample_t green_second;
        sample_t red_second;
    } bgr_beat_t;

    // chroma contributions shared by both lanes, in q16
    typedef struct packed {
        logic signed [ACC_W-1:0] blue_term;
        logic signed [ACC_W-1:0] green_term;
        logic signed [ACC_W-1:0] red_term;
    } chroma_terms_t;

    typedef struct packed {
        sample_t blue;
        sample_t green;
        sample_t red;
    } pixel_t;

endpackage

`default_nettype wire

// ===== rtl/ypbgr_chroma.sv =====
// shared chroma products for both pixels of a yuyv pair
`default_nettype none

module ypbgr_chroma
    import ypbgr_pkg::*;
(
    input  wire sample_t       chroma_blue,
    input  wire sample_t       chroma_red,
    output chroma_terms_t      terms
);

    logic signed [SAMPLE_W-1:0] du;
    logic signed [SAMPLE_W-1:0] dv;
    logic signed [PROD_W-1:0]   bu_prod;
    logic signed [PROD_W-1:0]   gu_prod;
    logic signed [PROD_W-1:0]   gv_prod;
    logic signed [PROD_W-1:0]   rv_prod;
    logic signed [ACC_W-1:0]    green_sum;

    // subtracting 128 from an 8-bit code is flipping its top bit
    assign du = $signed({~chroma_blue[SAMPLE_W-1], chroma_blue[SAMPLE_W-2:0]});
    assign dv = $signed({~chroma_red[SAMPLE_W-1], chroma_red[SAMPLE_W-2:0]});

    // operands sign-extended to the product width
    assign bu_prod = PROD_W'(COEF_BU) * PROD_W'(du);
    assign gu_prod = PROD_W'(COEF_GU) * PROD_W'(du);
    assign gv_prod = PROD_W'(COEF_GV) * PROD_W'(dv);
    assign rv_prod = PROD_W'(COEF_RV) * PROD_W'(dv);

    assign green_sum = ACC_W'(gv_prod) + ACC_W'(gu_prod);

    assign terms.blue_term  = ACC_W'(bu_prod);
    assign terms.green_term = -green_sum;
    assign terms.red_term   = ACC_W'(rv_prod);

endmodule

`default_nettype wire

// ===== rtl/ypbgr_lane.sv =====
// one pixel lane: adds luma to the chroma terms and saturates
`default_nettype none

module ypbgr_lane
    import ypbgr_pkg::*;
(
    input  wire sample_t       luma,
    input  wire chroma_terms_t terms,
    output pixel_t             pixel
);

    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] blue_acc;
    logic signed [ACC_W-1:0] green_acc;
    logic signed [ACC_W-1:0] red_acc;

    function automatic sample_t clamp(input logic signed [ACC_W-1:0] acc);
        sample_t res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end
        else if (|acc[ACC_W-2:FRAC_W+SAMPLE_W]) begin
            res = '1;
        end
        else begin
            res = acc[FRAC_W+SAMPLE_W-1:FRAC_W];
        end
        return res;
    endfunction

    assign base = $signed({{(ACC_W-SAMPLE_W-FRAC_W){1'b0}}, luma, {FRAC_W{1'b0}}});

    assign blue_acc  = base + terms.blue_term;
    assign green_acc = base + terms.green_term;
    assign red_acc   = base + terms.red_term;

    assign pixel.blue  = clamp(blue_acc);
    assign pixel.green = clamp(green_acc);
    assign pixel.red   = clamp(red_acc);

endmodule

`default_nettype wire

// ===== rtl/yuyv_pair_to_bgr888.sv =====
// top level of the yuyv 4:2:2 pair to bgr888 converter
//
// input channel yuyv_valid / yuyv_ready / yuyv carries one beat per pair:
// two luma samples with the u and v they share. output channel
// bgr_valid / bgr_ready / bgr carries one beat with both pixels as
// saturated 8-bit blue, green and red.
// pipeline: stage one registers the shared chroma products and both
// lumas, stage two (the output register) holds the two lane results.
// an accepted beat is registered in stage one and then in the output
// register, from which it is offered on bgr.
// throughput: one pair per cycle, limited by nothing but the handshake.
// when the receiver stalls, the output register holds its beat and stage
// one still takes a new pair if it is empty, so bubbles are squeezed out
// before the input is held off.
// reset clears both stage valids; no data register is reset.
`default_nettype none

`include "yuyv_pair_to_bgr888_assert.svh"

module yuyv_pair_to_bgr888
    import ypbgr_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             yuyv_valid,
    output logic            yuyv_ready,
    input  wire yuyv_beat_t yuyv,
    output logic            bgr_valid,
    input  wire             bgr_ready,
    output bgr_beat_t       bgr
);

    // stage one: shared chroma terms and the two lumas
    chroma_terms_t terms_comb;
    chroma_terms_t terms_reg;
    sample_t       luma_first_reg;
    sample_t       luma_second_reg;
    logic          s1_valid_reg;
    logic          s1_valid_next;

    // stage two: lane outputs merged into the output beat
    pixel_t        pixel_first;
    pixel_t        pixel_second;
    bgr_beat_t     bgr_reg;
    logic          bgr_valid_reg;
    logic          bgr_valid_next;

    logic          s2_en;
    logic          s1_en;
    logic          in_fire;

    // each stage moves when it is empty or the stage after it moves
    assign s2_en   = !bgr_valid_reg || bgr_ready;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign in_fire = yuyv_valid && s1_en;

    assign yuyv_ready = s1_en;
    assign bgr_valid  = bgr_valid_reg;
    assign bgr        = bgr_reg;

    ypbgr_chroma u_chroma (
        .chroma_blue (yuyv.chroma_blue),
        .chroma_red  (yuyv.chroma_red),
        .terms       (terms_comb)
    );

    // two copies of the pixel core, one per luma sample
    ypbgr_lane u_lane_first (
        .luma  (luma_first_reg),
        .terms (terms_reg),
        .pixel (pixel_first)
    );

    ypbgr_lane u_lane_second (
        .luma  (luma_second_reg),
        .terms (terms_reg),
        .pixel (pixel_second)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_en) begin
            s1_valid_next = yuyv_valid;
        end
        bgr_valid_next = bgr_valid_reg;
        if (s2_en) begin
            bgr_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            bgr_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            bgr_valid_reg <= bgr_valid_next;
        end
    end

    // payload registers, loaded only when a beat moves in
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            terms_reg       <= terms_comb;
            luma_first_reg  <= yuyv.luma_first;
            luma_second_reg <= yuyv.luma_second;
        end
        if (s2_en && s1_valid_reg) begin
            // merge: both lanes into one output beat
            bgr_reg.blue_first   <= pixel_first.blue;
            bgr_reg.green_first  <= pixel_first.green;
            bgr_reg.red_first    <= pixel_first.red;
            bgr_reg.blue_second  <= pixel_second.blue;
            bgr_reg.green_second <= pixel_second.green;
            bgr_reg.red_second   <= pixel_second.red;
        end
    end

    // an accepted pair always lands in stage one
    `YPB_ASSERT(a_accept_fills_s1, clk, rst_n, in_fire |=> s1_valid_reg)
    // a pair held in stage one behind a stalled output is not dropped
    `YPB_ASSERT(a_s1_holds, clk, rst_n, (s1_valid_reg && !s2_en) |=> s1_valid_reg)
    // a pair leaving stage one shows up on the output
    `YPB_ASSERT(a_s1_to_out, clk, rst_n, (s1_valid_reg && s2_en) |=> bgr_valid_reg)
    // the input is never held off while the output register is empty
    `YPB_ASSERT_ALWAYS(a_ready_when_empty, clk, !bgr_valid_reg |-> yuyv_ready)

endmodule

`default_nettype wire

// ===== tb/yuyv_bgr_checker.sv =====
// checker for the yuyv pair to bgr888 converter: predicts each pair and compares its beat
`timescale 1ns / 1ps

module yuyv_bgr_checker
    import ypbgr_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             yuyv_valid,
    input  wire             yuyv_ready,
    input  wire yuyv_beat_t yuyv,
    input  wire             bgr_valid,
    input  wire             bgr_ready,
    input  wire bgr_beat_t  bgr,
    output int              pending_pairs,
    output int              check_failures
);

    // q16 coefficients, rounded to nearest
    localparam int Q16_RED_V   = 92242;
    localparam int Q16_GREEN_V = 46983;
    localparam int Q16_GREEN_U = 22643;
    localparam int Q16_BLUE_U  = 116589;
    localparam int CHROMA_MID  = 128;
    localparam int SAMPLE_MAX  = 255;

    bgr_beat_t bgr_expected[$];

    initial begin
        pending_pairs  = 0;
        check_failures = 0;
    end

    // floor the q16 sum to a whole value and saturate to one byte
    function automatic sample_t saturate_q16(input int acc);
        int whole;
        if (acc < 0)
            return '0;
        whole = acc >>> 16;
        if (whole > SAMPLE_MAX)
            return sample_t'(SAMPLE_MAX);
        return sample_t'(whole);
    endfunction

    function automatic bgr_beat_t convert_pair(input yuyv_beat_t pair);
        bgr_beat_t px;
        int        du;
        int        dv;
        int        base_first;
        int        base_second;
        du          = int'(pair.chroma_blue) - CHROMA_MID;
        dv          = int'(pair.chroma_red) - CHROMA_MID;
        base_first  = int'(pair.luma_first) <<< 16;
        base_second = int'(pair.luma_second) <<< 16;
        px.blue_first   = saturate_q16(base_first + Q16_BLUE_U * du);
        px.green_first  = saturate_q16(base_first - Q16_GREEN_V * dv - Q16_GREEN_U * du);
        px.red_first    = saturate_q16(base_first + Q16_RED_V * dv);
        px.blue_second  = saturate_q16(base_second + Q16_BLUE_U * du);
        px.green_second = saturate_q16(base_second - Q16_GREEN_V * dv - Q16_GREEN_U * du);
        px.red_second   = saturate_q16(base_second + Q16_RED_V * dv);
        return px;
    endfunction

    task automatic compare_sample(input string field, input sample_t want, input sample_t got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            check_failures++;
        end
    endtask

    always @(posedge clk) begin
        bgr_beat_t want;
        if (rst_n) begin
            if (yuyv_valid && yuyv_ready)
                bgr_expected.push_back(convert_pair(yuyv));
            if (bgr_valid && bgr_ready) begin
                if (bgr_expected.size() == 0) begin
                    $error("bgr beat with no pair outstanding: %h", bgr);
                    check_failures++;
                end
                else begin
                    want = bgr_expected.pop_front();
                    compare_sample("blue_first", want.blue_first, bgr.blue_first);
                    compare_sample("green_first", want.green_first, bgr.green_first);
                    compare_sample("red_first", want.red_first, bgr.red_first);
                    compare_sample("blue_second", want.blue_second, bgr.blue_second);
                    compare_sample("green_second", want.green_second, bgr.green_second);
                    compare_sample("red_second", want.red_second, bgr.red_second);
                end
            end
        end
        pending_pairs <= bgr_expected.size();
    end

endmodule

// ===== tb/tb.sv =====
// top of the yuyv pair to bgr888 testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb
    import ypbgr_pkg::*;
();

    // receiver hold-off long enough to back the pipeline up into the input
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int PRESSURE_PAIRS  = 40;
    localparam int RANDOM_PAIRS    = 700;
    // the tail of the random part runs with both sides always ready
    localparam int STEADY_PAIRS    = 150;
    localparam int DRAIN_LIMIT     = 2000;
    // give the block some margin after the drain
    localparam int SETTLE_CYCLES   = 10;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       yuyv_valid  = 1'b0;
    yuyv_beat_t yuyv        = '0;
    logic       bgr_ready   = 1'b0;
    logic       yuyv_ready;
    logic       bgr_valid;
    bgr_beat_t  bgr;

    int         pending_pairs;
    int         check_failures;

    // shared with the receiver process
    bit         idle_enable   = 1'b1;
    bit         hold_off_req  = 1'b0;

    yuyv_pair_to_bgr888 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .yuyv_valid (yuyv_valid),
        .yuyv_ready (yuyv_ready),
        .yuyv       (yuyv),
        .bgr_valid  (bgr_valid),
        .bgr_ready  (bgr_ready),
        .bgr        (bgr)
    );

    yuyv_bgr_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .yuyv_valid     (yuyv_valid),
        .yuyv_ready     (yuyv_ready),
        .yuyv           (yuyv),
        .bgr_valid      (bgr_valid),
        .bgr_ready      (bgr_ready),
        .bgr            (bgr),
        .pending_pairs  (pending_pairs),
        .check_failures (check_failures)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // hard stop in case the handshake locks up
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // raise valid with the pair and hold it until the beat is taken;
    // returns in the time step of the accepting edge, so the next call
    // can keep valid high with a single nonblocking update
    task automatic offer_pair(input yuyv_beat_t pair);
        yuyv       <= pair;
        yuyv_valid <= 1'b1;
        @(posedge clk);
        while (!yuyv_ready)
            @(posedge clk);
    endtask

    // drop valid for a burst of cycles
    task automatic pause_input(input int cycles);
        yuyv_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // wait for every outstanding pair to come back, bounded
    task automatic wait_drained();
        int waited;
        waited = 0;
        while (pending_pairs != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
    endtask

    // extremes and mid scale show up more often than a flat draw would give
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            default: return sample_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic yuyv_beat_t random_pair();
        yuyv_beat_t pair;
        pair.luma_first  = pick_sample();
        pair.chroma_blue = pick_sample();
        pair.luma_second = pick_sample();
        pair.chroma_red  = pick_sample();
        return pair;
    endfunction

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                bgr_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0) begin
                bgr_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else begin
                bgr_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        // luma_first, chroma_blue, luma_second, chroma_red
        yuyv_beat_t directed[$] = '{
            '{8'd0,   8'd0,   8'd0,   8'd0},    // blue and red sums go negative
            '{8'd255, 8'd255, 8'd255, 8'd255},  // blue and red run past full scale
            '{8'd0,   8'd128, 8'd255, 8'd128},  // neutral chroma, black and white
            '{8'd128, 8'd128, 8'd128, 8'd128},  // mid grey
            '{8'd255, 8'd0,   8'd0,   8'd255},
            '{8'd0,   8'd255, 8'd255, 8'd0},
            '{8'd255, 8'd0,   8'd255, 8'd0},    // green clips high on both pixels
            '{8'd0,   8'd255, 8'd0,   8'd255},  // green clips low on both pixels
            '{8'd16,  8'd128, 8'd235, 8'd128},  // video range luma limits
            '{8'd127, 8'd127, 8'd129, 8'd129},  // chroma one step off center
            '{8'd1,   8'd129, 8'd254, 8'd127},
            '{8'd255, 8'd128, 8'd0,   8'd0},
            '{8'd0,   8'd0,   8'd255, 8'd255},
            '{8'd81,  8'd90,  8'd145, 8'd240},  // saturated red
            '{8'd41,  8'd240, 8'd210, 8'd110},  // saturated blue
            '{8'd170, 8'd166, 8'd106, 8'd16},   // cyan-ish
            '{8'd85,  8'd85,  8'd170, 8'd170},
            '{8'd170, 8'd170, 8'd85,  8'd85}
        };

        // asynchronous reset held low from the start, released on an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pairs, sent back to back
        foreach (directed[i])
            offer_pair(directed[i]);

        // long receiver hold-off while the sender keeps offering:
        // both stages fill and yuyv_ready must drop
        hold_off_req = 1'b1;
        repeat (PRESSURE_PAIRS)
            offer_pair(random_pair());
        while (hold_off_req)
            @(posedge clk);

        // sender pause until the pipeline has fully drained
        yuyv_valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // random part; the last stretch has no idling on either side
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == RANDOM_PAIRS - STEADY_PAIRS)
                idle_enable = 1'b0;
            if (idle_enable && $urandom_range(0, 4) == 0)
                pause_input($urandom_range(1, 13));
            offer_pair(random_pair());
        end
        yuyv_valid <= 1'b0;

        // drain, then watch a few more cycles for stray beats
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (check_failures == 0 && pending_pairs == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
